/* design/wfsa_pkg.sv */
// shared types, codes and defaults for the worst-fit segment allocator
package wfsa_pkg;

  localparam int DEF_ADDR_SPACE   = 256;
  localparam int DEF_MAX_SEGMENTS = 16;

  localparam logic [8:0] SPACE_LIMIT_RST = 9'd200;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [2:0] RC_OK         = 3'd0;
  localparam logic [2:0] RC_ZERO_LEN   = 3'd1;
  localparam logic [2:0] RC_NO_SPACE   = 3'd2;
  localparam logic [2:0] RC_NOT_FOUND  = 3'd3;
  localparam logic [2:0] RC_TABLE_FULL = 3'd4;
  localparam logic [2:0] RC_EXHAUSTED  = 3'd5;

  typedef struct packed {
    logic        func;
    logic [8:0]  req_length;
    logic [15:0] req_handle;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  result_code;
    logic [15:0] granted_handle;
    logic [7:0]  granted_start;
  } out_word_t;

endpackage

/* design/wfsa_ram.sv */
// generic simple dual-port ram with registered read
module wfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/worst_fit_segment_allocator.sv */
// worst-fit segment allocator: table in ram, scan then shift sequencer
//
//  channel  | ports                      | handshake
//  ---------+----------------------------+------------------------------
//  request  | start, busy, in_word       | taken when start & !busy
//  result   | out_valid, out_word        | one-cycle strobe, no stall
//  config   | cfg_we, cfg_wdata          | written when cfg_we
//
// an item scans the table, one ram read per table entry, then decides; a free, or
// an allocate that splits a free segment, then moves the entries above it one per
// cycle through the single read port, and a split then drops in the remnant. the
// result strobe comes last. zero length and exhausted handles answer without a
// scan.
// synchronous active-low reset empties the table; ram contents are left as is.
// busy stays high up to and including the result strobe; the receiver cannot stall.
module worst_fit_segment_allocator
  import wfsa_pkg::*;
#(
  parameter int ADDR_SPACE   = wfsa_pkg::DEF_ADDR_SPACE,
  parameter int MAX_SEGMENTS = wfsa_pkg::DEF_MAX_SEGMENTS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  wfsa_pkg::in_word_t  in_word,
  output logic                out_valid,
  output wfsa_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_wdata
);

  localparam int AW   = $clog2(ADDR_SPACE);
  localparam int CW   = ((AW + 1 > 9) ? AW + 1 : 9) + 1;
  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CNTW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SHIFT  = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  typedef struct packed {
    logic [15:0]   owner;
    logic          free;
    logic [AW-1:0] first;
    logic [AW-1:0] last;
  } seg_t;

  logic [2:0]      state_r, state_nxt;
  logic [8:0]      limit_r;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [15:0]     nh_r, nh_nxt;
  in_word_t        req_r, req_nxt;
  out_word_t       res_r, res_nxt;

  logic [IW-1:0]   k_r, k_nxt;
  logic            found_r, found_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   bsize_r, bsize_nxt;
  seg_t            pos_ent_r, pos_ent_nxt;
  seg_t            prev_r, prev_nxt;
  seg_t            pprev_r, pprev_nxt;
  seg_t            next_ent_r, next_ent_nxt;
  logic            pfree_r, pfree_nxt;
  logic            nfree_r, nfree_nxt;

  logic [IW-1:0]   rp_r, rp_nxt;
  logic [CNTW-1:0] left_r, left_nxt;
  logic            up_r, up_nxt;
  logic [1:0]      d_r, d_nxt;
  logic            infl_r, infl_nxt;
  logic [IW-1:0]   dst_r, dst_nxt;
  logic            tail_r, tail_nxt;
  seg_t            tail_ent_r, tail_ent_nxt;
  logic [IW-1:0]   tail_addr_r, tail_addr_nxt;

  logic            we;
  logic [IW-1:0]   waddr, raddr;
  seg_t            wdata, rdata;

  logic [CW-1:0]   lim_c, size_c, start_c, end_c, len_c;
  logic [CNTW:0]   src_c;

  wfsa_ram #(.WIDTH($bits(seg_t)), .DEPTH(MAX_SEGMENTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_FIN);
  assign out_word  = res_r;

  always_comb begin
    lim_c = (CW'(limit_r) > CW'(ADDR_SPACE)) ? CW'(ADDR_SPACE) : CW'(limit_r);
    len_c = CW'(req_r.req_length);
    size_c = CW'(rdata.last) - CW'(rdata.first) + CW'(1);
    if (found_r) begin
      start_c = CW'(pos_ent_r.first);
    end else if (count_r == '0) begin
      start_c = '0;
    end else begin
      start_c = CW'(prev_r.last) + CW'(1);
    end
    end_c = start_c + len_c;
    src_c = (CNTW+1)'(pos_r) + (CNTW+1)'(1) + (CNTW+1)'(nfree_r);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    nh_nxt        = nh_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    k_nxt         = k_r;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    bsize_nxt     = bsize_r;
    pos_ent_nxt   = pos_ent_r;
    prev_nxt      = prev_r;
    pprev_nxt     = pprev_r;
    next_ent_nxt  = next_ent_r;
    pfree_nxt     = pfree_r;
    nfree_nxt     = nfree_r;
    rp_nxt        = rp_r;
    left_nxt      = left_r;
    up_nxt        = up_r;
    d_nxt         = d_r;
    infl_nxt      = infl_r;
    dst_nxt       = dst_r;
    tail_nxt      = tail_r;
    tail_ent_nxt  = tail_ent_r;
    tail_addr_nxt = tail_addr_r;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt   = in_word;
          found_nxt = 1'b0;
          pfree_nxt = 1'b0;
          nfree_nxt = 1'b0;
          k_nxt     = '0;
          bsize_nxt = '0;
          res_nxt   = '0;
          if (in_word.func == FUNC_ALLOC && in_word.req_length == '0) begin
            res_nxt.result_code = RC_ZERO_LEN;
            state_nxt = ST_FIN;
          end else if (in_word.func == FUNC_ALLOC && nh_r == '0) begin
            res_nxt.result_code = RC_EXHAUSTED;
            state_nxt = ST_FIN;
          end else if (count_r == '0) begin
            state_nxt = ST_DECIDE;
          end else begin
            raddr     = '0;
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // rdata holds entry k_r
        raddr     = k_r + IW'(1);
        prev_nxt  = rdata;
        pprev_nxt = prev_r;
        if (req_r.func == FUNC_ALLOC) begin
          if (rdata.free && size_c >= len_c && (!found_r || size_c >= bsize_r)) begin
            found_nxt   = 1'b1;
            pos_nxt     = k_r;
            bsize_nxt   = size_c;
            pos_ent_nxt = rdata;
          end
        end else begin
          if (!found_r && !rdata.free && rdata.owner == req_r.req_handle) begin
            found_nxt   = 1'b1;
            pos_nxt     = k_r;
            pos_ent_nxt = rdata;
            pfree_nxt   = (k_r != '0) && prev_r.free;
            pprev_nxt   = prev_r;
          end else if (found_r) begin
            pprev_nxt = pprev_r;
          end
          if (found_r && k_r == pos_r + IW'(1)) begin
            next_ent_nxt = rdata;
            nfree_nxt    = rdata.free;
          end
        end
        k_nxt = k_r + IW'(1);
        if (CNTW'(k_r) + CNTW'(1) >= count_r) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        res_nxt = '0;
        infl_nxt = 1'b0;
        tail_nxt = 1'b0;
        state_nxt = ST_FIN;
        if (req_r.func == FUNC_ALLOC) begin
          if (end_c > lim_c) begin
            res_nxt.result_code = RC_NO_SPACE;
          end else if (found_r && bsize_r == len_c) begin
            we    = 1'b1;
            waddr = pos_r;
            wdata = '{owner: nh_r, free: 1'b0, first: pos_ent_r.first,
                      last: pos_ent_r.last};
            res_nxt.granted_handle = nh_r;
            res_nxt.granted_start  = start_c[7:0];
            nh_nxt = nh_r + 16'd1;
          end else if (count_r >= CNTW'(MAX_SEGMENTS)) begin
            res_nxt.result_code = RC_TABLE_FULL;
          end else begin
            we    = 1'b1;
            waddr = found_r ? pos_r : count_r[IW-1:0];
            wdata = '{owner: nh_r, free: 1'b0, first: start_c[AW-1:0],
                      last: AW'(end_c - CW'(1))};
            res_nxt.granted_handle = nh_r;
            res_nxt.granted_start  = start_c[7:0];
            nh_nxt    = nh_r + 16'd1;
            count_nxt = count_r + CNTW'(1);
            if (found_r) begin
              // split: move the entries above up by one, then drop in the remnant
              tail_nxt      = 1'b1;
              tail_addr_nxt = pos_r + IW'(1);
              tail_ent_nxt  = '{owner: 16'd0, free: 1'b1, first: end_c[AW-1:0],
                                last: pos_ent_r.last};
              up_nxt    = 1'b1;
              rp_nxt    = IW'(count_r - CNTW'(1));
              left_nxt  = count_r - CNTW'(pos_r) - CNTW'(1);
              state_nxt = ST_SHIFT;
            end
          end
        end else begin
          if (!found_r) begin
            res_nxt.result_code = RC_NOT_FOUND;
          end else begin
            we    = 1'b1;
            waddr = pfree_r ? pos_r - IW'(1) : pos_r;
            wdata = '{owner: 16'd0, free: 1'b1,
                      first: pfree_r ? pprev_r.first : pos_ent_r.first,
                      last: nfree_r ? next_ent_r.last : pos_ent_r.last};
            // close the gap left by the merged neighbors
            d_nxt     = 2'(pfree_r) + 2'(nfree_r);
            up_nxt    = 1'b0;
            rp_nxt    = src_c[IW-1:0];
            left_nxt  = CNTW'((CNTW+1)'(count_r) - src_c);
            count_nxt = count_r - CNTW'(pfree_r) - CNTW'(nfree_r);
            state_nxt = ST_SHIFT;
          end
        end
      end

      ST_SHIFT: begin
        if (infl_r) begin
          we    = 1'b1;
          waddr = dst_r;
          wdata = rdata;
        end
        raddr = rp_r;
        if (left_r != '0) begin
          infl_nxt = 1'b1;
          dst_nxt  = up_r ? rp_r + IW'(1) : rp_r - IW'(d_r);
          rp_nxt   = up_r ? rp_r - IW'(1) : rp_r + IW'(1);
          left_nxt = left_r - CNTW'(1);
        end else begin
          infl_nxt = 1'b0;
          if (!infl_r) begin
            state_nxt = tail_r ? ST_TAIL : ST_FIN;
          end
        end
      end

      ST_TAIL: begin
        we        = 1'b1;
        waddr     = tail_addr_r;
        wdata     = tail_ent_r;
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      limit_r <= SPACE_LIMIT_RST;
      count_r <= '0;
      nh_r    <= 16'd1;
      infl_r  <= 1'b0;
      tail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      nh_r    <= nh_nxt;
      infl_r  <= infl_nxt;
      tail_r  <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    res_r       <= res_nxt;
    k_r         <= k_nxt;
    found_r     <= found_nxt;
    pos_r       <= pos_nxt;
    bsize_r     <= bsize_nxt;
    pos_ent_r   <= pos_ent_nxt;
    prev_r      <= prev_nxt;
    pprev_r     <= pprev_nxt;
    next_ent_r  <= next_ent_nxt;
    pfree_r     <= pfree_nxt;
    nfree_r     <= nfree_nxt;
    rp_r        <= rp_nxt;
    left_r      <= left_nxt;
    up_r        <= up_nxt;
    d_r         <= d_nxt;
    dst_r       <= dst_nxt;
    tail_ent_r  <= tail_ent_nxt;
    tail_addr_r <= tail_addr_nxt;
  end

endmodule
